// ===== design/pt_pkg.sv =====
// Shared types and constants for the progress timer.
`timescale 1ns / 1ps

package pt_pkg;

    localparam int TIME_W = 32;
    localparam int PROG_W = 8;
    localparam int CMD_W  = 2;
    localparam int BIT_W  = $clog2(PROG_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_RESET = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELAP,
        S_CMP,
        S_CALC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] duration_ms;
    } t_in_item;

    typedef struct packed {
        logic              running;
        logic              done_res;
        logic [PROG_W-1:0] progress;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scale_stat;

endpackage

// ===== design/pt_scale.sv =====
// Bit-serial scaler that computes floor(elapsed * max / duration) for elapsed < duration.
`timescale 1ns / 1ps

module pt_scale
    import pt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_elapsed,
    input  logic [PROG_W-1:0] i_max,
    input  logic [TIME_W-1:0] i_dur,
    output t_scale_stat       o_stat,
    output logic [PROG_W-1:0] o_quot
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_phase, n_phase;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [TIME_W-1:0] r_rem, n_rem;
    logic [PROG_W-1:0] r_quot, n_quot;

    logic [TIME_W:0]   w_opnd;
    logic [TIME_W+1:0] w_diff;
    logic              w_ge;

    // One shared add and compare: phase 0 doubles the remainder, phase 1 adds
    // elapsed when the current bit of max is set. Both reduce modulo duration.
    always_comb begin
        if (!r_phase) begin
            w_opnd = {r_rem, 1'b0};
        end else if (i_max[r_bit]) begin
            w_opnd = {1'b0, r_rem} + {1'b0, i_elapsed};
        end else begin
            w_opnd = {1'b0, r_rem};
        end
        w_diff = {1'b0, w_opnd} - {2'b00, i_dur};
        w_ge   = ~w_diff[TIME_W+1];
    end

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_quot  = r_quot;
        if (i_start) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_bit   = BIT_W'(PROG_W - 1);
            n_rem   = '0;
            n_quot  = '0;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[TIME_W-1:0] : w_opnd[TIME_W-1:0];
            if (!r_phase) begin
                n_quot  = {r_quot[PROG_W-2:0], w_ge};
                n_phase = 1'b1;
            end else begin
                n_quot  = r_quot + PROG_W'(w_ge);
                n_phase = 1'b0;
                if (r_bit == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_phase <= n_phase;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ===== design/progress_timer_unit.sv =====
// Top level of the progress timer: command sequencer, time state and result register.
`timescale 1ns / 1ps

// Each accepted item (tick, start or reset) updates the time state and
// produces one status item with running, done_res and progress. Items are
// processed one at a time. A result that needs no scaling (idle or finished)
// skips the scaler. Otherwise the bit-serial scaler runs a doubling and an
// add phase for each of the 8 progress bits. The next item can be taken in
// the cycle after the result is loaded. The input is stalled while an item
// is in work; a finished result sits in the output register, so the next
// item can be taken while it waits. progress_max resets to 255 and should
// be written only while the block is idle.
module progress_timer_unit
    import pt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PROG_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_start, n_start;
    logic [TIME_W-1:0] r_dur, n_dur;
    logic [PROG_W-1:0] r_pmax, n_pmax;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic              r_running, n_running;
    logic              r_done, n_done;
    logic [PROG_W-1:0] r_prog, n_prog;

    logic              w_scale_start;
    t_scale_stat       w_scale_stat;
    logic [PROG_W-1:0] w_scale_quot;

    pt_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_scale_start),
        .i_elapsed (r_elapsed),
        .i_max     (r_pmax),
        .i_dur     (r_dur),
        .o_stat    (w_scale_stat),
        .o_quot    (w_scale_quot)
    );

    always_comb begin
        n_state       = r_state;
        n_now         = r_now;
        n_start       = r_start;
        n_dur         = r_dur;
        n_pmax        = r_pmax;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        n_elapsed     = r_elapsed;
        n_running     = r_running;
        n_done        = r_done;
        n_prog        = r_prog;
        w_scale_start = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_pmax = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_cmd'(i_in_data.cmd))
                        CMD_TICK: begin
                            n_now = r_now + 1'b1;
                        end
                        CMD_START: begin
                            n_start = r_now;
                            n_dur   = i_in_data.duration_ms;
                        end
                        CMD_RESET: begin
                            n_start = '0;
                            n_dur   = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_ELAP;
                end
            end
            S_ELAP: begin
                // Wraps modulo the counter width, so a start before a wrap still works.
                n_elapsed = r_now - r_start;
                n_state   = S_CMP;
            end
            S_CMP: begin
                n_running = (r_dur != '0);
                if (r_dur == '0) begin
                    n_done  = 1'b0;
                    n_prog  = '0;
                    n_state = S_EMIT;
                end else if (r_elapsed >= r_dur) begin
                    n_done  = 1'b1;
                    n_prog  = r_pmax;
                    n_state = S_EMIT;
                end else begin
                    n_done        = 1'b0;
                    w_scale_start = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                if (w_scale_stat.done) begin
                    n_prog  = w_scale_quot;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.running    = r_running;
                    n_out.done_res   = r_done;
                    n_out.progress   = r_prog;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_start     <= '0;
            r_dur       <= '0;
            r_pmax      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_start     <= n_start;
            r_dur       <= n_dur;
            r_pmax      <= n_pmax;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_elapsed <= n_elapsed;
        r_running <= n_running;
        r_done    <= n_done;
        r_prog    <= n_prog;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_scale_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_scale_stat.busy || w_scale_stat.done) |-> (r_state == S_CALC))
        else $error("scaler active outside the scaling state");

    a_accept_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_ELAP))
        else $error("accepted item did not start processing");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || !i_out_stall)) |=>
        (o_out_valid && r_state == S_IDLE))
        else $error("finished item was not placed in the output register");
`endif

endmodule
